// ===== hdl/metropolis_spin_flip_update_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spin flip update block
// Shared implication forms with clock and reset arguments.
// ----------------------------------------------------------------------------
`ifndef METROPOLIS_SPIN_FLIP_UPDATE_MACROS_SVH
`define METROPOLIS_SPIN_FLIP_UPDATE_MACROS_SVH

// same-cycle implication
`define MSFU_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("msfu assertion failed");

// next-cycle implication
`define MSFU_ASSERT_NXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("msfu assertion failed");

`endif

// ===== hdl/msfu_pkg.sv =====
// ----------------------------------------------------------------------------
// msfu_pkg
// Constants, command and status types and the exponential table function.
// ----------------------------------------------------------------------------
package msfu_pkg;

    localparam int SIDE        = 32;
    localparam int CW          = $clog2(SIDE);
    localparam int AW          = 2 * CW;
    localparam int DEPTH       = 1 << AW;
    localparam int D2_W        = 2 * CW + 1;
    localparam int RECIP_W     = 17;
    localparam int FAR_W       = 2 * CW + 18;
    localparam int NEAR_W      = 19;
    localparam int CPL_W       = 16;
    localparam int FIELD_W     = 20;
    localparam int BETA_W      = 24;
    localparam int LRS_W       = 24;
    localparam int MAGP_W      = FAR_W - 1 + LRS_W;
    localparam int LR_W        = MAGP_W - 14;
    localparam int LOC_W       = LR_W + 2;
    localparam int DE_W        = LOC_W + 1;
    localparam int DEO_W       = 32;
    localparam int PROD_W      = 31 + BETA_W;
    localparam int IX_SHIFT    = 14;
    localparam int EXP_ENTRIES = 1024;
    localparam int EXP_AW      = $clog2(EXP_ENTRIES);
    localparam int EXP_W       = 17;
    localparam int SUM_W       = 12;
    localparam int U_W         = 16;
    localparam int IN_CW       = 5;
    localparam int CFG_IW      = 2;
    localparam int CFG_DW      = 24;

    localparam logic [31:0] DECAY_STEP = 32'd4228380000;

    localparam logic [CFG_IW-1:0] CFG_FIELD = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_LRS   = 2'd2;

    localparam logic signed [FIELD_W-1:0] FIELD_RESET = 20'sd1229;
    localparam logic [BETA_W-1:0]         BETA_RESET  = 24'd256000;
    localparam logic [LRS_W-1:0]          LRS_RESET   = 24'd369;
    localparam logic signed [CPL_W-1:0]   CPL_RESET   = -16'sd4096;

    typedef struct packed {
        logic clr;
        logic cap;
        logic load_rd;
        logic load_wr;
        logic fin_off;
        logic rd1;
        logic rd2;
        logic sw_run;
        logic cnt_clr;
        logic do_mul;
        logic do_sum;
        logic do_idx;
        logic do_exp;
        logic fin_trial;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
        logic in_func;
        logic in_off;
    } t_sts;

    function automatic logic [EXP_W-1:0] exp_entry(input int k);
        logic [63:0] acc;
        logic [95:0] t;
        int          i;
        acc = 64'd1 << 32;
        for (i = 1; i <= k; i++) begin
            t   = 96'(acc) * 96'(DECAY_STEP) + (96'd1 << 31);
            acc = t[95:32];
        end
        t = 96'(acc) + 96'd32768;
        return EXP_W'(t >> 16);
    endfunction

endpackage

// ===== hdl/msfu_ram.sv =====
// ----------------------------------------------------------------------------
// msfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msfu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/msfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// msfu_ctrl
// Sequencer: clearing pass, load, off-lattice words, trial sweep and accept steps.
// ----------------------------------------------------------------------------
`include "metropolis_spin_flip_update_macros.svh"

module msfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  msfu_pkg::t_sts i_sts,
    output msfu_pkg::t_cmd o_cmd
);
    import msfu_pkg::*;

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_LOAD_RD = 4'd2;
    localparam logic [3:0] ST_LOAD_WR = 4'd3;
    localparam logic [3:0] ST_OFF     = 4'd4;
    localparam logic [3:0] ST_RD1     = 4'd5;
    localparam logic [3:0] ST_RD2     = 4'd6;
    localparam logic [3:0] ST_SWEEP   = 4'd7;
    localparam logic [3:0] ST_DRAIN1  = 4'd8;
    localparam logic [3:0] ST_DRAIN2  = 4'd9;
    localparam logic [3:0] ST_MUL     = 4'd10;
    localparam logic [3:0] ST_SUM     = 4'd11;
    localparam logic [3:0] ST_IDX     = 4'd12;
    localparam logic [3:0] ST_EXP     = 4'd13;
    localparam logic [3:0] ST_FIN     = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.cap = 1'b1;
                    if (i_sts.in_off)       n_state = ST_OFF;
                    else if (i_sts.in_func) n_state = ST_RD1;
                    else                    n_state = ST_LOAD_RD;
                end
            end
            ST_LOAD_RD: begin
                o_cmd.load_rd = 1'b1;
                n_state = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_wr = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_OFF: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_off = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RD1: begin
                o_cmd.rd1     = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.sw_run = 1'b1;
                if (i_sts.cnt_last) n_state = ST_DRAIN1;
            end
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_MUL;
            ST_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state = ST_IDX;
            end
            ST_IDX: begin
                o_cmd.do_idx = 1'b1;
                n_state = ST_EXP;
            end
            ST_EXP: begin
                o_cmd.do_exp = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_trial = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `MSFU_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != ST_IDLE)
    `MSFU_ASSERT_IMP(a_sweep_not_clear, i_clk, i_rst_n, o_cmd.sw_run, r_state != ST_CLEAR)
    `MSFU_ASSERT_NXT(a_sweep_end_drains, i_clk, i_rst_n,
                     o_cmd.sw_run && i_sts.cnt_last, r_state == ST_DRAIN1)

endmodule

// ===== hdl/msfu_dp.sv =====
// ----------------------------------------------------------------------------
// msfu_dp
// Lattice stores, long-range sweep accumulator, energy and accept datapath.
// ----------------------------------------------------------------------------
`include "metropolis_spin_flip_update_macros.svh"

module msfu_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msfu_pkg::t_cmd                    i_cmd,
    output msfu_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_valid,
    input  logic [msfu_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [msfu_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                              i_func,
    input  logic [msfu_pkg::IN_CW-1:0]        i_row,
    input  logic [msfu_pkg::IN_CW-1:0]        i_col,
    input  logic                              i_spin_in,
    input  logic signed [msfu_pkg::CPL_W-1:0] i_coupling_right,
    input  logic signed [msfu_pkg::CPL_W-1:0] i_coupling_down,
    input  logic [msfu_pkg::U_W-1:0]          i_rand_u,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_spin_now,
    output logic                              o_accepted,
    output logic signed [msfu_pkg::DEO_W-1:0] o_delta_energy,
    output logic signed [msfu_pkg::SUM_W-1:0] o_magnetization
);
    import msfu_pkg::*;

    localparam int RECIP_N = 1 << D2_W;
    localparam int EXP_N   = 1 << EXP_AW;
    localparam logic signed [DE_W-1:0] DE_MAX = DE_W'(64'sd2147483647);
    localparam logic signed [DE_W-1:0] DE_MIN = ~DE_MAX;

    logic [RECIP_W-1:0] w_recip_tab [RECIP_N];
    logic [EXP_W-1:0]   w_exp_tab   [EXP_N];

    for (genvar g = 0; g < RECIP_N; g++) begin : g_recip
        localparam int RD = (g == 0) ? 1 : g;
        localparam logic [RECIP_W-1:0] RV =
            (g == 0) ? '0 : RECIP_W'((65536 + g / 2) / RD);
        assign w_recip_tab[g] = RV;
    end

    for (genvar g = 0; g < EXP_N; g++) begin : g_exp
        localparam logic [EXP_W-1:0] EV = exp_entry(g);
        assign w_exp_tab[g] = EV;
    end

    // configuration
    logic signed [FIELD_W-1:0] r_field;
    logic [BETA_W-1:0]         r_beta;
    logic [LRS_W-1:0]          r_lrs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= FIELD_RESET;
            r_beta  <= BETA_RESET;
            r_lrs   <= LRS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIELD: r_field <= i_cfg_data[FIELD_W-1:0];
                CFG_BETA:  r_beta  <= i_cfg_data[BETA_W-1:0];
                CFG_LRS:   r_lrs   <= i_cfg_data[LRS_W-1:0];
                default:   r_field <= r_field;
            endcase
        end
    end

    // captured item
    logic [CW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic                r_spin_in;
    logic [CPL_W-1:0]    r_cpl_r_in;
    logic [CPL_W-1:0]    r_cpl_d_in;
    logic [U_W-1:0]      r_u;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_row      <= CW'(i_row);
            r_col      <= CW'(i_col);
            r_spin_in  <= i_spin_in;
            r_cpl_r_in <= i_coupling_right;
            r_cpl_d_in <= i_coupling_down;
            r_u        <= i_rand_u;
        end
    end

    logic [AW-1:0] w_idx;
    assign w_idx = {r_row, r_col};

    // site counter for clearing and sweep
    logic [CW-1:0] r_cnt_row;
    logic [CW-1:0] r_cnt_col;
    logic          w_cnt_last;
    logic          w_cnt_inc;

    assign w_cnt_last = (r_cnt_row == CW'(SIDE - 1)) && (r_cnt_col == CW'(SIDE - 1));
    assign w_cnt_inc  = i_cmd.clr || i_cmd.sw_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cnt_clr) begin
            r_cnt_row <= '0;
            r_cnt_col <= '0;
        end else if (w_cnt_inc) begin
            if (r_cnt_col == CW'(SIDE - 1)) begin
                r_cnt_col <= '0;
                r_cnt_row <= w_cnt_last ? '0 : r_cnt_row + 1'b1;
            end else begin
                r_cnt_col <= r_cnt_col + 1'b1;
            end
        end
    end

    // stores
    logic           w_sp_we;
    logic [AW-1:0]  w_sp_waddr;
    logic [0:0]     w_sp_wdata;
    logic [AW-1:0]  w_sp_raddr;
    logic [0:0]     w_sp_rdata;
    logic           w_cp_we;
    logic [AW-1:0]  w_cp_waddr;
    logic [CPL_W-1:0] w_cr_wdata;
    logic [CPL_W-1:0] w_cd_wdata;
    logic [AW-1:0]  w_cr_raddr;
    logic [AW-1:0]  w_cd_raddr;
    logic [CPL_W-1:0] w_cr_rdata;
    logic [CPL_W-1:0] w_cd_rdata;
    logic [AW-1:0]  r_k1;
    logic           r_v1;
    logic           w_accept_flip;
    logic           r_spin_self;

    assign w_cp_we    = i_cmd.clr || i_cmd.load_wr;
    assign w_cp_waddr = i_cmd.clr ? {r_cnt_row, r_cnt_col} : w_idx;
    assign w_cr_wdata = i_cmd.clr ? CPL_RESET : r_cpl_r_in;
    assign w_cd_wdata = i_cmd.clr ? CPL_RESET : r_cpl_d_in;
    assign w_cr_raddr = i_cmd.rd2 ? {r_row - 1'b1, r_col} : w_idx;
    assign w_cd_raddr = i_cmd.rd2 ? {r_row, r_col - 1'b1} : w_idx;

    assign w_sp_we    = i_cmd.clr || i_cmd.load_wr || (i_cmd.fin_trial && w_accept_flip);
    assign w_sp_waddr = i_cmd.clr ? {r_cnt_row, r_cnt_col} : w_idx;
    assign w_sp_wdata = i_cmd.clr ? 1'b1 : (i_cmd.load_wr ? r_spin_in : ~r_spin_self);
    assign w_sp_raddr = r_v1 ? r_k1 : w_idx;

    msfu_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (w_sp_we),
        .i_waddr (w_sp_waddr),
        .i_wdata (w_sp_wdata),
        .i_raddr (w_sp_raddr),
        .o_rdata (w_sp_rdata)
    );

    msfu_ram #(.WIDTH(CPL_W), .DEPTH(DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_cp_we),
        .i_waddr (w_cp_waddr),
        .i_wdata (w_cr_wdata),
        .i_raddr (w_cr_raddr),
        .o_rdata (w_cr_rdata)
    );

    msfu_ram #(.WIDTH(CPL_W), .DEPTH(DEPTH)) u_down_ram (
        .i_clk   (i_clk),
        .i_we    (w_cp_we),
        .i_waddr (w_cp_waddr),
        .i_wdata (w_cd_wdata),
        .i_raddr (w_cd_raddr),
        .o_rdata (w_cd_rdata)
    );

    // neighbor couplings
    logic signed [CPL_W-1:0] r_cr_self;
    logic signed [CPL_W-1:0] r_cd_self;
    logic signed [CPL_W-1:0] r_cr_up;
    logic signed [CPL_W-1:0] r_cd_left;
    logic                    r_rd2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd2_d <= 1'b0;
        end else begin
            r_rd2_d <= i_cmd.rd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd2) begin
            r_cr_self <= w_cr_rdata;
            r_cd_self <= w_cd_rdata;
        end
        if (r_rd2_d) begin
            r_cr_up   <= w_cr_rdata;
            r_cd_left <= w_cd_rdata;
        end
    end

    // sweep pipeline: distance, reciprocal lookup, accumulate
    logic signed [CW:0]   w_dr;
    logic signed [CW:0]   w_dc;
    logic [2*CW+1:0]      w_dr2;
    logic [2*CW+1:0]      w_dc2;
    logic [D2_W-1:0]      r_d2;
    logic                 r_v2;
    logic [AW-1:0]        r_k2;
    logic [RECIP_W-1:0]   r_recip;

    assign w_dr  = $signed({1'b0, r_cnt_row}) - $signed({1'b0, r_row});
    assign w_dc  = $signed({1'b0, r_cnt_col}) - $signed({1'b0, r_col});
    assign w_dr2 = $unsigned((2*CW+2)'(w_dr * w_dr));
    assign w_dc2 = $unsigned((2*CW+2)'(w_dc * w_dc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.sw_run;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2    <= D2_W'(w_dr2 + w_dc2);
        r_k1    <= {r_cnt_row, r_cnt_col};
        r_k2    <= r_k1;
        r_recip <= w_recip_tab[r_d2];
    end

    logic [CW-1:0]            w_k2_row;
    logic [CW-1:0]            w_k2_col;
    logic                     w_s2;
    logic                     w_hit_dn;
    logic                     w_hit_rt;
    logic                     w_hit_up;
    logic                     w_hit_lf;
    logic signed [CPL_W-1:0]  w_ncoef;
    logic signed [NEAR_W-1:0] w_nterm;
    logic signed [FAR_W-1:0]  w_fterm;
    logic signed [FAR_W-1:0]  r_far;
    logic signed [NEAR_W-1:0] r_near;

    assign w_k2_row = r_k2[AW-1:CW];
    assign w_k2_col = r_k2[CW-1:0];
    assign w_s2     = w_sp_rdata[0];
    assign w_hit_dn = (32'(r_row) + 1 < SIDE) && ({1'b0, w_k2_row} == {1'b0, r_row} + 1'b1)
                      && (w_k2_col == r_col);
    assign w_hit_rt = (32'(r_col) + 1 < SIDE) && ({1'b0, w_k2_col} == {1'b0, r_col} + 1'b1)
                      && (w_k2_row == r_row);
    assign w_hit_up = (r_row != '0) && (w_k2_row == r_row - 1'b1) && (w_k2_col == r_col);
    assign w_hit_lf = (r_col != '0) && (w_k2_col == r_col - 1'b1) && (w_k2_row == r_row);

    always_comb begin
        w_ncoef = '0;
        if (w_hit_dn)      w_ncoef = r_cr_self;
        else if (w_hit_rt) w_ncoef = r_cd_self;
        else if (w_hit_up) w_ncoef = r_cr_up;
        else if (w_hit_lf) w_ncoef = r_cd_left;
    end

    assign w_nterm = w_s2 ? NEAR_W'(w_ncoef) : -NEAR_W'(w_ncoef);
    assign w_fterm = w_s2 ? $signed(FAR_W'(r_recip)) : -$signed(FAR_W'(r_recip));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd1) begin
            r_far  <= '0;
            r_near <= '0;
        end else if (r_v2) begin
            r_far  <= r_far + w_fterm;
            r_near <= r_near + w_nterm;
            if (r_k2 == w_idx) r_spin_self <= w_s2;
        end
    end

    // long-range scale, energy change, table index, table read
    logic [FAR_W-2:0]          w_far_abs;
    logic [MAGP_W-1:0]         r_mag;
    logic                      r_far_neg;
    logic [MAGP_W:0]           w_rnd;
    logic signed [LR_W-1:0]    w_lr;
    logic signed [LOC_W-1:0]   w_loc;
    logic signed [DE_W-1:0]    w_de2;
    logic signed [DE_W-1:0]    w_de;
    logic signed [DEO_W-1:0]   r_de;
    logic                      r_de_pos;
    logic [PROD_W-1:0]         r_prod;
    logic [EXP_W-1:0]          r_exp;
    logic                      r_ix_ok;

    assign w_far_abs = r_far[FAR_W-1] ? (FAR_W-1)'(-r_far) : r_far[FAR_W-2:0];
    assign w_rnd     = (MAGP_W+1)'(r_mag) + (MAGP_W+1)'(32768);
    assign w_lr      = r_far_neg ? -$signed({1'b0, w_rnd[MAGP_W:16]})
                                 : $signed({1'b0, w_rnd[MAGP_W:16]});
    assign w_loc     = LOC_W'(r_near) + LOC_W'(w_lr) - LOC_W'(r_field);
    assign w_de2     = $signed({w_loc, 1'b0});
    assign w_de      = r_spin_self ? -w_de2 : w_de2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_mul) begin
            r_mag     <= MAGP_W'(w_far_abs) * MAGP_W'(r_lrs);
            r_far_neg <= r_far[FAR_W-1];
        end
        if (i_cmd.do_sum) begin
            if (w_de > DE_MAX)      r_de <= DEO_W'(DE_MAX);
            else if (w_de < DE_MIN) r_de <= DEO_W'(DE_MIN);
            else                    r_de <= DEO_W'(w_de);
        end
        if (i_cmd.do_idx) begin
            r_de_pos <= (r_de > 0);
            r_prod   <= PROD_W'(r_de[30:0]) * PROD_W'(r_beta);
        end
        if (i_cmd.do_exp) begin
            r_exp   <= w_exp_tab[r_prod[IX_SHIFT +: EXP_AW]];
            r_ix_ok <= (r_prod >> IX_SHIFT) < PROD_W'(EXP_ENTRIES);
        end
    end

    assign w_accept_flip = !r_de_pos || (r_ix_ok && ({1'b0, r_u} < r_exp));

    // magnetization
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = r_sum;
        if (i_cmd.load_wr && (r_spin_in != w_sp_rdata[0])) begin
            n_sum = r_spin_in ? r_sum + SUM_W'(2) : r_sum - SUM_W'(2);
        end else if (i_cmd.fin_trial && w_accept_flip) begin
            n_sum = r_spin_self ? r_sum - SUM_W'(2) : r_sum + SUM_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_W'(SIDE * SIDE);
        end else begin
            r_sum <= n_sum;
        end
    end

    // output register
    logic                    r_out_valid;
    logic                    r_o_spin;
    logic                    r_o_acc;
    logic signed [DEO_W-1:0] r_o_de;
    logic signed [SUM_W-1:0] r_o_mag;
    logic                    w_fin;

    assign w_fin = i_cmd.load_wr || i_cmd.fin_off || i_cmd.fin_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_o_mag <= n_sum;
            if (i_cmd.load_wr) begin
                r_o_spin <= r_spin_in;
                r_o_acc  <= 1'b0;
                r_o_de   <= '0;
            end else if (i_cmd.fin_off) begin
                r_o_spin <= 1'b0;
                r_o_acc  <= 1'b0;
                r_o_de   <= '0;
            end else begin
                r_o_spin <= w_accept_flip ? ~r_spin_self : r_spin_self;
                r_o_acc  <= w_accept_flip;
                r_o_de   <= r_de;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_spin_now      = r_o_spin;
    assign o_accepted      = r_o_acc;
    assign o_delta_energy  = r_o_de;
    assign o_magnetization = r_o_mag;

    assign o_sts.cnt_last = w_cnt_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.in_func  = i_func;
    assign o_sts.in_off   = (32'(i_row) >= SIDE) || (32'(i_col) >= SIDE);

    `MSFU_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_fin, !r_out_valid || i_out_ready)
    `MSFU_ASSERT_NXT(a_fin_shows, i_clk, i_rst_n, w_fin, r_out_valid)
    `MSFU_ASSERT_IMP(a_sum_step, i_clk, i_rst_n, $past(i_rst_n),
                     (r_sum == $past(r_sum)) || (r_sum == $past(r_sum) + SUM_W'(2))
                     || (r_sum == $past(r_sum) - SUM_W'(2)))

endmodule

// ===== hdl/metropolis_spin_flip_update.sv =====
// ----------------------------------------------------------------------------
// metropolis_spin_flip_update
// Metropolis single-spin-flip engine on a square Ising lattice.
// ----------------------------------------------------------------------------
// One item at a time: a new word is taken only after the last result is
// registered. A load word passes a read step and a write step. For a trial
// word the long-range sum reads every site from the spin RAM once, one site
// per cycle, followed by pipeline drain, scale, energy, exponent index and
// table read steps. A result that is not taken holds the block until the
// output register frees. After reset a clearing pass writes every site's spin
// and couplings; input words are held off until it ends, configuration writes
// are taken at any time.
module metropolis_spin_flip_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [msfu_pkg::IN_CW-1:0]        i_row,
    input  logic [msfu_pkg::IN_CW-1:0]        i_col,
    input  logic                              i_spin_in,
    input  logic signed [msfu_pkg::CPL_W-1:0] i_coupling_right,
    input  logic signed [msfu_pkg::CPL_W-1:0] i_coupling_down,
    input  logic [msfu_pkg::U_W-1:0]          i_rand_u,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_spin_now,
    output logic                              o_accepted,
    output logic signed [msfu_pkg::DEO_W-1:0] o_delta_energy,
    output logic signed [msfu_pkg::SUM_W-1:0] o_magnetization,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [msfu_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [msfu_pkg::CFG_DW-1:0]       i_cfg_data
);
    import msfu_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    msfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    msfu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_spin_in        (i_spin_in),
        .i_coupling_right (i_coupling_right),
        .i_coupling_down  (i_coupling_down),
        .i_rand_u         (i_rand_u),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_spin_now       (o_spin_now),
        .o_accepted       (o_accepted),
        .o_delta_energy   (o_delta_energy),
        .o_magnetization  (o_magnetization)
    );

endmodule

// ===== dv/metropolis_spin_flip_update_test.sv =====
// ----------------------------------------------------------------------------
// metropolis_spin_flip_update_test
// Drives load and trial words through the spin flip engine under several
// field, temperature and long-range settings. A behavioral lattice model in
// the bench predicts magnetization of every word and spin, accept flag and
// energy change of every untyped word; the results are compared in order,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module metropolis_spin_flip_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msfu_pkg::*;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_TRIAL = 1'b1;
    localparam int   N_SITES    = SIDE * SIDE;
    localparam int   N_RANDOM   = 560;
    localparam int   N_PHASES   = 4;

    typedef struct {
        bit                      typed;
        logic                    func;
        logic [IN_CW-1:0]        row;
        logic [IN_CW-1:0]        col;
        logic                    spin;
        logic signed [CPL_W-1:0] cpl_right;
        logic signed [CPL_W-1:0] cpl_down;
        logic [U_W-1:0]          rand_u;
        logic                    e_spin;
        logic                    e_acc;
        logic signed [31:0]      e_de;
    } t_word;

    typedef struct {
        logic                    spin;
        logic                    acc;
        logic signed [31:0]      de;
        logic [SUM_W-1:0]        mag;
    } t_flip_result;

    localparam int N_PLAN = 18;
    t_word plan [0:N_PLAN-1] = '{
        '{1'b0, FUNC_TRIAL, 5'd0,  5'd0,  1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b1, FUNC_LOAD,  5'd0,  5'd0,  1'b0, 16'sd32767, -16'sd32768, 16'd0,
          1'b0, 1'b0, 32'sd0},
        '{1'b1, FUNC_LOAD,  5'd31, 5'd31, 1'b1, -16'sd32768, 16'sd32767, 16'd65535,
          1'b1, 1'b0, 32'sd0},
        '{1'b1, FUNC_LOAD,  5'd0,  5'd31, 1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b1, FUNC_LOAD,  5'd31, 5'd0,  1'b1, 16'sd4096, -16'sd4096, 16'd0,
          1'b1, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd0,  5'd0,  1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd0,  5'd0,  1'b1, 16'sd0, 16'sd0, 16'd65535, 1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd31, 5'd31, 1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd31, 5'd31, 1'b0, 16'sd0, 16'sd0, 16'd65535, 1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd0,  5'd31, 1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd31, 5'd0,  1'b0, 16'sd0, 16'sd0, 16'd32768, 1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd15, 5'd16, 1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b1, FUNC_LOAD,  5'd15, 5'd16, 1'b0, 16'sd32767, 16'sd32767, 16'd1,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd15, 5'd16, 1'b0, 16'sd0, 16'sd0, 16'd65535, 1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd15, 5'd15, 1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd16, 5'd16, 1'b1, 16'sd0, 16'sd0, 16'd32768, 1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd14, 5'd16, 1'b0, 16'sd0, 16'sd0, 16'd1,     1'b0, 1'b0, 32'sd0},
        '{1'b0, FUNC_TRIAL, 5'd15, 5'd16, 1'b0, 16'sd0, 16'sd0, 16'd0,     1'b0, 1'b0, 32'sd0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_func = 1'b0;
    logic [IN_CW-1:0]        i_row = '0;
    logic [IN_CW-1:0]        i_col = '0;
    logic                    i_spin_in = 1'b0;
    logic signed [CPL_W-1:0] i_coupling_right = '0;
    logic signed [CPL_W-1:0] i_coupling_down = '0;
    logic [U_W-1:0]          i_rand_u = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_spin_now;
    logic                    o_accepted;
    logic signed [DEO_W-1:0] o_delta_energy;
    logic signed [SUM_W-1:0] o_magnetization;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IW-1:0]       i_cfg_index = '0;
    logic [CFG_DW-1:0]       i_cfg_data = '0;

    metropolis_spin_flip_update DUT (.*);

    always #2 i_clk = ~i_clk;

    // lattice model state
    bit                      lat_spin [N_SITES];
    logic signed [CPL_W-1:0] lat_right [N_SITES];
    logic signed [CPL_W-1:0] lat_down [N_SITES];
    int                      spin_total;
    longint                  field_h;
    longint                  beta;
    longint                  lr_coef;
    longint                  recip [0:2*SIDE*SIDE];
    longint                  boltzmann [EXP_ENTRIES];

    t_flip_result pending_results [$];
    int  errors = 0;
    int  words_sent = 0;
    bit  stall_req = 1'b0;
    bit  quiet_in = 1'b0;
    bit  quiet_out = 1'b0;

    function automatic longint site_sign(int idx);
        return lat_spin[idx] ? 64'sd1 : -64'sd1;
    endfunction

    function automatic void lattice_reset();
        logic [127:0] acc;
        for (int k = 0; k < N_SITES; k++) begin
            lat_spin[k]  = 1'b1;
            lat_right[k] = -16'sd4096;
            lat_down[k]  = -16'sd4096;
        end
        spin_total = N_SITES;
        field_h = 1229;
        beta = 256000;
        lr_coef = 369;
        for (int d = 1; d <= 2*SIDE*SIDE; d++) recip[d] = (65536 + d / 2) / d;
        acc = 128'd1 << 32;
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            if (k > 0) acc = (acc * 128'd4228380000 + (128'd1 << 31)) >> 32;
            boltzmann[k] = longint'((acc + 128'd32768) >> 16);
        end
    endfunction

    function automatic longint flip_energy(int r, int c);
        int     idx;
        longint near_sum, far_sum, mag, local_field, de;
        idx = r * SIDE + c;
        near_sum = 0;
        far_sum = 0;
        if (r + 1 < SIDE) near_sum += longint'(lat_right[idx]) * site_sign(idx + SIDE);
        if (c + 1 < SIDE) near_sum += longint'(lat_down[idx]) * site_sign(idx + 1);
        if (r > 0) near_sum += longint'(lat_right[idx - SIDE]) * site_sign(idx - SIDE);
        if (c > 0) near_sum += longint'(lat_down[idx - 1]) * site_sign(idx - 1);
        for (int rr = 0; rr < SIDE; rr++) begin
            for (int cc = 0; cc < SIDE; cc++) begin
                if (rr != r || cc != c)
                    far_sum += recip[(rr-r)*(rr-r) + (cc-c)*(cc-c)] * site_sign(rr*SIDE + cc);
            end
        end
        mag = ((far_sum < 0 ? -far_sum : far_sum) * lr_coef + 32768) >>> 16;
        local_field = near_sum + (far_sum < 0 ? -mag : mag) - field_h;
        de = lat_spin[idx] ? -2 * local_field : 2 * local_field;
        if (de > 64'sd2147483647) de = 64'sd2147483647;
        if (de < -64'sd2147483648) de = -64'sd2147483648;
        return de;
    endfunction

    function automatic t_flip_result apply_word(t_word w);
        t_flip_result res;
        int     idx;
        longint de, ix;
        idx = int'(w.row) * SIDE + int'(w.col);
        res.acc = 1'b0;
        res.de  = '0;
        if (w.func == FUNC_LOAD) begin
            spin_total += (w.spin ? 1 : -1) - int'(site_sign(idx));
            lat_spin[idx]  = w.spin;
            lat_right[idx] = w.cpl_right;
            lat_down[idx]  = w.cpl_down;
        end else begin
            de = flip_energy(int'(w.row), int'(w.col));
            res.de = 32'(de);
            if (de <= 0) begin
                res.acc = 1'b1;
            end else begin
                ix = (de * beta) >>> IX_SHIFT;
                if (ix < EXP_ENTRIES && longint'(w.rand_u) < boltzmann[ix]) res.acc = 1'b1;
            end
            if (res.acc) begin
                spin_total -= 2 * int'(site_sign(idx));
                lat_spin[idx] = ~lat_spin[idx];
            end
        end
        res.spin = lat_spin[idx];
        res.mag  = SUM_W'(spin_total);
        if (w.typed) begin
            res.spin = w.e_spin;
            res.acc  = w.e_acc;
            res.de   = w.e_de;
        end
        return res;
    endfunction

    task automatic send_word(t_word w);
        int gap;
        i_in_valid       <= 1'b1;
        i_func           <= w.func;
        i_row            <= w.row;
        i_col            <= w.col;
        i_spin_in        <= w.spin;
        i_coupling_right <= w.cpl_right;
        i_coupling_down  <= w.cpl_down;
        i_rand_u         <= w.rand_u;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(apply_word(w));
        words_sent++;
        gap = (!quiet_in && $urandom_range(0, 99) < 34) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] index, logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_FIELD: field_h = longint'(signed'(data[FIELD_W-1:0]));
            CFG_BETA:  beta = longint'(data[BETA_W-1:0]);
            CFG_LRS:   lr_coef = longint'(data[LRS_W-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_word random_word();
        t_word w;
        w.typed     = 1'b0;
        w.func      = ($urandom_range(0, 99) < 30) ? FUNC_LOAD : FUNC_TRIAL;
        w.row       = IN_CW'($urandom_range(0, SIDE - 1));
        w.col       = IN_CW'($urandom_range(0, SIDE - 1));
        w.spin      = 1'($urandom);
        w.cpl_right = CPL_W'($urandom);
        w.cpl_down  = CPL_W'($urandom);
        w.rand_u    = U_W'($urandom);
        w.e_spin    = 1'b0;
        w.e_acc     = 1'b0;
        w.e_de      = '0;
        return w;
    endfunction

    // hold, then release the result side; the long stall is counted here
    always @(posedge i_clk) begin
        static int stall_left = 0;
        static bit stall_done = 1'b0;
        if (stall_req && !stall_done) begin
            stall_done = 1'b1;
            stall_left = 4000;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_out || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        t_flip_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word", $realtime);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_spin_now !== exp_r.spin) begin
                    $display("%0t: spin_now expected %0d actual %0d", $realtime, exp_r.spin,
                             o_spin_now);
                    errors++;
                end
                if (o_accepted !== exp_r.acc) begin
                    $display("%0t: accepted expected %0d actual %0d", $realtime, exp_r.acc,
                             o_accepted);
                    errors++;
                end
                if (o_delta_energy !== exp_r.de) begin
                    $display("%0t: delta_energy expected %0d actual %0d", $realtime, exp_r.de,
                             o_delta_energy);
                    errors++;
                end
                if (o_magnetization !== exp_r.mag) begin
                    $display("%0t: magnetization expected %0d actual %0d", $realtime,
                             signed'(exp_r.mag), o_magnetization);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        lattice_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < N_PLAN; p++) send_word(plan[p]);
        drain();
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_FIELD, CFG_DW'(-524288));
                    write_reg(CFG_BETA, 24'hFFFFFF);
                    write_reg(CFG_LRS, 24'd0);
                end
                1: begin
                    write_reg(CFG_FIELD, CFG_DW'(524287));
                    write_reg(CFG_BETA, 24'd0);
                    write_reg(CFG_LRS, 24'hFFFFFF);
                end
                2: begin
                    write_reg(CFG_FIELD, CFG_DW'($urandom_range(0, 20000)) - 24'd10000);
                    write_reg(CFG_BETA, CFG_DW'($urandom_range(1, 400)));
                    write_reg(CFG_LRS, CFG_DW'($urandom_range(0, 2000)));
                end
                default: begin
                    write_reg(CFG_FIELD, CFG_DW'($urandom));
                    write_reg(CFG_BETA, CFG_DW'($urandom));
                    write_reg(CFG_LRS, CFG_DW'($urandom));
                end
            endcase
            for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
                quiet_in  = (ph == 2 && n >= 20 && n < 60);
                quiet_out = quiet_in;
                if (ph == 1 && n == 40) stall_req = 1'b1;
                send_word(random_word());
            end
            quiet_in  = 1'b0;
            quiet_out = 1'b0;
            drain();
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
